// ===== hw/rtl/eilc_pkg.sv =====
// Shared types, register offsets and helper functions for the external
// interrupt latch controller. No dependencies.
package eilc_pkg;

  // Channel count limits.
  localparam int unsigned MAX_CHANNELS     = 32;
  localparam int unsigned DEFAULT_CHANNELS = 32;

  // Request kinds carried by an input beat.
  typedef enum logic [1:0] {
    REQ_PIN   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NOP   = 2'd3
  } req_kind_t;

  // Bus register offsets.
  localparam logic [7:0] OFS_ENABLE  = 8'h00;
  localparam logic [7:0] OFS_PENDING = 8'h04;
  localparam logic [7:0] OFS_CLEAR   = 8'h08;
  localparam logic [7:0] OFS_MODE_LO = 8'h0C;
  localparam logic [7:0] OFS_MODE_HI = 8'h10;
  localparam logic [7:0] OFS_NMI_REQ = 8'h14;
  localparam logic [7:0] OFS_NMI_CLR = 8'h18;

  // Constant read values.
  localparam logic [31:0] CLEAR_RD_VAL   = 32'hffff_ffff;
  localparam logic [31:0] NMI_REQ_RD_VAL = 32'h0000_0000;
  localparam logic [31:0] NMI_CLR_RD_VAL = 32'h0000_0001;
  localparam logic [31:0] LOW_GROUP      = 32'h0000_00ff;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE_LOW  = 2'd0;
  localparam logic [1:0] CFG_MODE_HIGH = 2'd1;
  localparam logic [1:0] CFG_ROUTE     = 2'd2;

  // Trigger modes and stored signal codes share one encoding.
  localparam logic [1:0] MODE_LOW_LEVEL  = 2'd0;
  localparam logic [1:0] MODE_HIGH_LEVEL = 2'd1;
  localparam logic [1:0] MODE_RISING     = 2'd2;
  localparam logic [1:0] MODE_FALLING    = 2'd3;

  localparam logic [31:0] ROUTE_RESET = 32'hffff_ffff;

  // One input item.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  channel;
    logic        pin_level;
    logic [7:0]  reg_offset;
    logic [31:0] write_data;
  } eilc_item_t;

  // One result item.
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_low;
    logic        irq_high;
  } eilc_result_t;

  // Two-bit trigger mode of a channel from the two mode registers.
  function automatic logic [1:0] chan_mode(input logic [31:0] mode_lo,
                                           input logic [31:0] mode_hi,
                                           input logic [4:0]  ch);
    logic [4:0] shift;
    shift = {ch[3:0], 1'b0};
    if (!ch[4]) begin
      return mode_lo[shift +: 2];
    end
    return mode_hi[shift +: 2];
  endfunction

  // True for the two level-sensitive modes.
  function automatic logic is_level_mode(input logic [1:0] mode);
    return (mode == MODE_LOW_LEVEL) || (mode == MODE_HIGH_LEVEL);
  endfunction

endpackage

// ===== hw/rtl/eilc_in_if.sv =====
// Input channel interface: valid/ready handshake plus one request beat.
// Depends on nothing.
interface eilc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [4:0]  channel;
  logic        pin_level;
  logic [7:0]  reg_offset;
  logic [31:0] write_data;

  modport source(output valid, req_type, channel, pin_level, reg_offset, write_data,
                 input ready);
  modport sink(input valid, req_type, channel, pin_level, reg_offset, write_data,
               output ready);
endinterface

// ===== hw/rtl/eilc_out_if.sv =====
// Result channel interface: valid/ready handshake plus one result beat.
// Depends on nothing.
interface eilc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_low;
  logic        irq_high;

  modport source(output valid, read_data, irq_low, irq_high, input ready);
  modport sink(input valid, read_data, irq_low, irq_high, output ready);
endinterface

// ===== hw/rtl/eilc_cfg_if.sv =====
// Configuration write channel interface: register index and write data.
// Depends on nothing.
interface eilc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [31:0] data;

  modport source(output valid, reg_index, data, input ready);
  modport sink(input valid, reg_index, data, output ready);
endinterface

// ===== hw/rtl/eilc_in_reg.sv =====
// Input register stage: captures one request beat and holds it until the
// result stage can take it. Depends on eilc_pkg.
module eilc_in_reg
  import eilc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  eilc_item_t in_item,
  input  logic       advance,
  output logic       s1_valid,
  output eilc_item_t s1_item
);

  logic       valid_r;
  logic       valid_nxt;
  eilc_item_t item_r;
  logic       in_fire;

  // The stage empties when its beat advances, so it can refill in that cycle.
  assign in_ready = !valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ===== hw/rtl/eilc_core.sv =====
// Controller state and per-beat logic: mode, route, enable and pending
// registers, stored pin signals, and the result of one request. Depends on eilc_pkg.
module eilc_core
  import eilc_pkg::*;
#(
  parameter int unsigned CHANNELS = DEFAULT_CHANNELS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         fire,
  input  eilc_item_t   item,
  output eilc_result_t result
);

  localparam int unsigned IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [5:0]  CHAN_LIMIT = 6'(CHANNELS);

  logic [31:0] mode_low_r;
  logic [31:0] mode_high_r;
  logic [31:0] route_r;
  logic [31:0] enable_r;
  logic [31:0] enable_nxt;
  logic [31:0] pending_r;
  logic [31:0] pending_nxt;

  // Stored pin signal per channel: valid flag plus two-bit code.
  logic       sig_valid_r [CHANNELS];
  logic [1:0] sig_code_r  [CHANNELS];

  logic             sig_we;
  logic [IDX_W-1:0] sig_idx;
  logic [1:0]       sig_code;
  logic [31:0]      again;
  logic [31:0]      read_data;
  logic [31:0]      req;
  logic [1:0]       ev_mode;
  logic             ev_ok;

  // Level-mode channels whose stored signal still matches their mode.
  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_again
    if (c < CHANNELS) begin : g_live
      logic [1:0] mode_c;
      assign mode_c   = chan_mode(mode_low_r, mode_high_r, 5'(c));
      assign again[c] = is_level_mode(mode_c) && sig_valid_r[c] &&
                        (sig_code_r[c] == mode_c);
    end else begin : g_unused
      assign again[c] = 1'b0;
    end
  end

  assign ev_mode = chan_mode(mode_low_r, mode_high_r, item.channel);
  assign ev_ok   = ({1'b0, item.channel} < CHAN_LIMIT) && route_r[item.channel];

  // Next state and read data for the beat in the input register.
  always_comb begin
    enable_nxt  = enable_r;
    pending_nxt = pending_r;
    read_data   = '0;
    sig_we      = 1'b0;
    sig_idx     = item.channel[IDX_W-1:0];
    sig_code    = is_level_mode(ev_mode) ? {1'b0, item.pin_level} :
                  (item.pin_level ? MODE_RISING : MODE_FALLING);
    case (req_kind_t'(item.req_type))
      REQ_PIN: begin
        if (ev_ok) begin
          sig_we                    = 1'b1;
          pending_nxt[item.channel] = (sig_code == ev_mode);
        end
      end
      REQ_READ: begin
        case (item.reg_offset)
          OFS_ENABLE:  read_data = enable_r;
          OFS_PENDING: read_data = pending_r;
          OFS_CLEAR:   read_data = CLEAR_RD_VAL;
          OFS_MODE_LO: read_data = mode_low_r;
          OFS_MODE_HI: read_data = mode_high_r;
          OFS_NMI_REQ: read_data = NMI_REQ_RD_VAL;
          OFS_NMI_CLR: read_data = NMI_CLR_RD_VAL;
          default:     read_data = '0;
        endcase
      end
      REQ_WRITE: begin
        if (item.reg_offset == OFS_ENABLE) begin
          enable_nxt = item.write_data;
        end else if (item.reg_offset == OFS_CLEAR) begin
          pending_nxt = (pending_r & item.write_data) | again;
        end
      end
      default: begin
      end
    endcase
  end

  // Result reflects the state after this beat.
  assign req              = pending_nxt & enable_nxt;
  assign result.read_data = read_data;
  assign result.irq_low   = |(req & LOW_GROUP);
  assign result.irq_high  = |(req & ~LOW_GROUP);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_low_r  <= '0;
      mode_high_r <= '0;
      route_r     <= ROUTE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE_LOW:  mode_low_r  <= cfg_data;
        CFG_MODE_HIGH: mode_high_r <= cfg_data;
        CFG_ROUTE:     route_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Enable and pending masks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= '0;
      pending_r <= '0;
    end else if (fire) begin
      enable_r  <= enable_nxt;
      pending_r <= pending_nxt;
    end
  end

  // Signal valid flags are cleared by reset; codes are plain payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sig_valid_r[i] <= 1'b0;
      end
    end else if (fire && sig_we) begin
      sig_valid_r[sig_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && sig_we) begin
      sig_code_r[sig_idx] <= sig_code;
    end
  end

endmodule

// ===== hw/rtl/eilc_out_reg.sv =====
// Result register: holds one result beat until the sink takes it.
// Depends on eilc_pkg.
module eilc_out_reg
  import eilc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  eilc_result_t load_result,
  output logic         free,
  output logic         out_valid,
  input  logic         out_ready,
  output eilc_result_t out_result
);

  logic         valid_r;
  logic         valid_nxt;
  eilc_result_t result_r;

  // Free when empty or when the held beat leaves this cycle.
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= load_result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

// ===== hw/rtl/external_interrupt_latch_controller_core.sv =====
// External interrupt latch controller, top level.
// A beat accepted into the input register moves into the result register when
// that register is free, and leaves when the sink is ready. Throughput: one beat
// per cycle while the sink does not stall, set by the input and result registers.
// Synchronous active-low reset clears valid flags, modes, enable and pending
// masks, and sets the route mask; stored pin signals read as unseen at once.
module external_interrupt_latch_controller_core
  import eilc_pkg::*;
#(
  parameter int unsigned CHANNELS = DEFAULT_CHANNELS
) (
  input logic    clk,
  input logic    rst_n,
  eilc_in_if.sink    in_bus,
  eilc_out_if.source out_bus,
  eilc_cfg_if.sink   cfg_bus
);

  eilc_item_t   in_item;
  eilc_item_t   s1_item;
  eilc_result_t core_result;
  eilc_result_t out_result;
  logic         s1_valid;
  logic         out_free;
  logic         fire;

  // Configuration writes are always taken.
  assign cfg_bus.ready = 1'b1;

  assign in_item.req_type   = in_bus.req_type;
  assign in_item.channel    = in_bus.channel;
  assign in_item.pin_level  = in_bus.pin_level;
  assign in_item.reg_offset = in_bus.reg_offset;
  assign in_item.write_data = in_bus.write_data;

  assign fire = s1_valid && out_free;

  eilc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .in_item  (in_item),
    .advance  (out_free),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  eilc_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_bus.valid),
    .cfg_index (cfg_bus.reg_index),
    .cfg_data  (cfg_bus.data),
    .fire      (fire),
    .item      (s1_item),
    .result    (core_result)
  );

  eilc_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (fire),
    .load_result (core_result),
    .free        (out_free),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .out_result  (out_result)
  );

  assign out_bus.read_data = out_result.read_data;
  assign out_bus.irq_low   = out_result.irq_low;
  assign out_bus.irq_high  = out_result.irq_high;

endmodule

// ===== hw/rtl/eilc_checker.sv =====
// Port-level checks for the interrupt controller top level, and the bind
// that attaches them. Depends on external_interrupt_latch_controller_core.
module eilc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_data,
  input logic        out_irq_low,
  input logic        out_irq_high
);

  // A held result beat stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A held result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_read_data) && $stable(out_irq_low) &&
                                $stable(out_irq_high))
    else $error("result payload changed while stalled");

  // Input side stalls only behind a stalled result.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // An accepted beat reaches the result register when the sink is ready.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 out_ready |=> out_valid)
    else $error("accepted beat did not produce a result");

endmodule

bind external_interrupt_latch_controller_core eilc_checker u_eilc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_read_data (out_bus.read_data),
  .out_irq_low   (out_bus.irq_low),
  .out_irq_high  (out_bus.irq_high)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for external_interrupt_latch_controller_core: a scripted opening
// and random phases under several trigger-mode settings, checked beat by beat.
// Depends on eilc_pkg, the three channel interfaces and the top level from the RTL tree.
module testbench;
  import eilc_pkg::*;

  // The config port has one index that maps to no register.
  localparam logic [1:0] CFG_SPARE = 2'd3;
  // Cycles with no handshake on any channel before the run is called hung.
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES = 8;
  localparam int BEATS_PER_PHASE = 250;

  // One row of the scripted opening: either a register write or a request beat.
  typedef struct {
    bit           is_cfg;
    logic [1:0]   cfg_idx;
    logic [31:0]  cfg_value;
    eilc_item_t   item;
    bit           known;
    eilc_result_t reply;
  } script_row_t;

  logic clk;
  logic rst_n;

  eilc_in_if  in_bus();
  eilc_out_if out_bus();
  eilc_cfg_if cfg_bus();

  external_interrupt_latch_controller_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  // Shadow copy of the controller's registers and latched pin signals.
  logic [31:0] shadow_mode_lo;
  logic [31:0] shadow_mode_hi;
  logic [31:0] shadow_route;
  logic [31:0] shadow_enable;
  logic [31:0] shadow_pending;
  logic [31:0] sig_seen;
  logic [1:0]  sig_code [32];

  eilc_result_t reply_q [$];
  script_row_t  script [$];
  int items_sent;
  int results_seen;
  int mismatches;
  int quiet_cycles;
  int tx_idle_pct;
  int rx_idle_pct;
  int tx_calm;
  int rx_calm;
  bit in_live;
  bit cfg_live;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Two-bit trigger mode of one channel as the shadow registers hold it.
  function automatic logic [1:0] trigger_mode(int unsigned ch);
    if (ch < 16) begin
      return shadow_mode_lo[2 * ch +: 2];
    end
    return shadow_mode_hi[2 * (ch - 16) +: 2];
  endfunction

  // Applies one request beat to the shadow state and returns the reply it earns.
  function automatic eilc_result_t latch_step(eilc_item_t it);
    eilc_result_t res;
    logic [31:0]  rd;
    logic [31:0]  again;
    logic [31:0]  live;
    logic [1:0]   m;
    logic [1:0]   code;
    int unsigned  ch;
    rd = '0;
    again = '0;
    ch = it.channel;
    case (it.req_type)
      REQ_PIN: begin
        if (ch < DEFAULT_CHANNELS && shadow_route[ch]) begin
          m = trigger_mode(ch);
          // Level modes store the pin level; edge modes store rising or falling.
          if (m == MODE_LOW_LEVEL || m == MODE_HIGH_LEVEL) begin
            code = it.pin_level ? MODE_HIGH_LEVEL : MODE_LOW_LEVEL;
          end else begin
            code = it.pin_level ? MODE_RISING : MODE_FALLING;
          end
          sig_seen[ch] = 1'b1;
          sig_code[ch] = code;
          shadow_pending[ch] = (code == m);
        end
      end
      REQ_READ: begin
        case (it.reg_offset)
          OFS_ENABLE:  rd = shadow_enable;
          OFS_PENDING: rd = shadow_pending;
          OFS_CLEAR:   rd = 32'hffff_ffff;
          OFS_MODE_LO: rd = shadow_mode_lo;
          OFS_MODE_HI: rd = shadow_mode_hi;
          OFS_NMI_REQ: rd = 32'd0;
          OFS_NMI_CLR: rd = 32'd1;
          default:     rd = '0;
        endcase
      end
      REQ_WRITE: begin
        if (it.reg_offset == OFS_ENABLE) begin
          shadow_enable = it.write_data;
        end else if (it.reg_offset == OFS_CLEAR) begin
          // Clearing masks the pending bits, then level channels still asserted relatch.
          shadow_pending &= it.write_data;
          for (int c = 0; c < DEFAULT_CHANNELS; c++) begin
            m = trigger_mode(c);
            if ((m == MODE_LOW_LEVEL || m == MODE_HIGH_LEVEL) && sig_seen[c] &&
                sig_code[c] == m) begin
              again[c] = 1'b1;
            end
          end
          shadow_pending |= again;
        end
      end
      default: ;
    endcase
    live = shadow_pending & shadow_enable;
    res.read_data = rd;
    res.irq_low = |live[7:0];
    res.irq_high = |live[31:8];
    return res;
  endfunction

  function automatic eilc_item_t beat(req_kind_t kind, int ch, logic lvl, logic [7:0] ofs,
                                      logic [31:0] data);
    eilc_item_t it;
    it.req_type = kind;
    it.channel = 5'(ch);
    it.pin_level = lvl;
    it.reg_offset = ofs;
    it.write_data = data;
    return it;
  endfunction

  task automatic add_beat(eilc_item_t it);
    script_row_t row;
    row.is_cfg = 1'b0;
    row.item = it;
    row.known = 1'b0;
    row.reply = '0;
    script.push_back(row);
  endtask

  task automatic add_known(eilc_item_t it, logic [31:0] rd, logic il, logic ih);
    script_row_t row;
    row.is_cfg = 1'b0;
    row.item = it;
    row.known = 1'b1;
    row.reply.read_data = rd;
    row.reply.irq_low = il;
    row.reply.irq_high = ih;
    script.push_back(row);
  endtask

  task automatic add_cfg(logic [1:0] idx, logic [31:0] value);
    script_row_t row;
    row.is_cfg = 1'b1;
    row.cfg_idx = idx;
    row.cfg_value = value;
    row.known = 1'b0;
    script.push_back(row);
  endtask

  function automatic logic [7:0] mapped_offset();
    case ($urandom_range(0, 6))
      0:       return OFS_ENABLE;
      1:       return OFS_PENDING;
      2:       return OFS_CLEAR;
      3:       return OFS_MODE_LO;
      4:       return OFS_MODE_HI;
      5:       return OFS_NMI_REQ;
      default: return OFS_NMI_CLR;
    endcase
  endfunction

  // Mostly pin events and accesses to mapped registers, with some noise offsets.
  function automatic eilc_item_t random_beat();
    eilc_item_t  it;
    int unsigned pick;
    it.channel = 5'($urandom_range(0, 31));
    it.pin_level = 1'($urandom_range(0, 1));
    it.reg_offset = 8'($urandom_range(0, 255));
    it.write_data = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.req_type = REQ_PIN;
    end else if (pick < 70) begin
      it.req_type = REQ_READ;
      if ($urandom_range(0, 99) < 85) begin
        it.reg_offset = mapped_offset();
      end
    end else if (pick < 95) begin
      it.req_type = REQ_WRITE;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        it.reg_offset = OFS_ENABLE;
      end else if (pick < 8) begin
        it.reg_offset = OFS_CLEAR;
      end else if (pick == 8) begin
        it.reg_offset = mapped_offset();
      end
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
        it.write_data = '0;
      end else if (pick == 1) begin
        it.write_data = '1;
      end
    end else begin
      it.req_type = REQ_NOP;
    end
    return it;
  endfunction

  // Sender gap decision for one cycle; occasional calm stretches have no gaps.
  function automatic bit sender_rests();
    if (tx_calm > 0) begin
      tx_calm--;
      return 1'b0;
    end
    if ($urandom_range(0, 99) < 3) begin
      tx_calm = $urandom_range(10, 40);
      return 1'b0;
    end
    return $urandom_range(0, 99) < tx_idle_pct;
  endfunction

  // Drives one register write and mirrors it once the beat is taken.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.data <= value;
    cfg_live = 1'b1;
    @(posedge clk);
    while (cfg_bus.ready !== 1'b1) @(posedge clk);
    case (idx)
      CFG_MODE_LOW:  shadow_mode_lo = value;
      CFG_MODE_HIGH: shadow_mode_hi = value;
      CFG_ROUTE:     shadow_route = value;
      default: ;
    endcase
  endtask

  // Drives one request beat; a known reply overrides the predicted one.
  task automatic send_item(eilc_item_t it, bit known, eilc_result_t known_reply);
    eilc_result_t guess;
    if (cfg_live) begin
      cfg_bus.valid <= 1'b0;
      cfg_live = 1'b0;
    end
    while (sender_rests()) begin
      if (in_live) begin
        in_bus.valid <= 1'b0;
        in_live = 1'b0;
      end
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.req_type <= it.req_type;
    in_bus.channel <= it.channel;
    in_bus.pin_level <= it.pin_level;
    in_bus.reg_offset <= it.reg_offset;
    in_bus.write_data <= it.write_data;
    in_live = 1'b1;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    guess = latch_step(it);
    reply_q.push_back(known ? known_reply : guess);
    items_sent++;
  endtask

  // Holds the request channel quiet until every outstanding reply has come back.
  task automatic quiesce();
    if (in_live) begin
      in_bus.valid <= 1'b0;
      in_live = 1'b0;
    end
    while (results_seen < items_sent) @(posedge clk);
  endtask

  task automatic flag(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch on reply %0d: expected %h, got %h", $realtime, field,
               results_seen, want, got);
    end
  endtask

  // Result receiver: random stalls, with calm stretches where it always accepts.
  always @(posedge clk) begin
    if (rx_calm > 0) begin
      rx_calm--;
      out_bus.ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 3) begin
      rx_calm = $urandom_range(10, 40);
      out_bus.ready <= 1'b1;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Every result beat is compared with the oldest predicted reply.
  always @(posedge clk) begin
    eilc_result_t want;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (reply_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result beat with no reply outstanding, read_data %h", $realtime,
                   out_bus.read_data);
        end
      end else begin
        want = reply_q.pop_front();
        if (out_bus.read_data !== want.read_data) begin
          flag("read_data", want.read_data, out_bus.read_data);
        end
        if (out_bus.irq_low !== want.irq_low) begin
          flag("irq_low", 32'(want.irq_low), 32'(out_bus.irq_low));
        end
        if (out_bus.irq_high !== want.irq_high) begin
          flag("irq_high", 32'(want.irq_high), 32'(out_bus.irq_high));
        end
      end
      results_seen++;
    end
  end

  // Watchdog: too long without a handshake on any channel ends the run.
  always @(posedge clk) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) ||
        (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] rt;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.req_type = REQ_NOP;
    in_bus.channel = '0;
    in_bus.pin_level = 1'b0;
    in_bus.reg_offset = '0;
    in_bus.write_data = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.reg_index = CFG_MODE_LOW;
    cfg_bus.data = '0;
    shadow_mode_lo = '0;
    shadow_mode_hi = '0;
    shadow_route = 32'hffff_ffff;
    shadow_enable = '0;
    shadow_pending = '0;
    sig_seen = '0;
    foreach (sig_code[i]) sig_code[i] = MODE_LOW_LEVEL;
    items_sent = 0;
    results_seen = 0;
    mismatches = 0;
    quiet_cycles = 0;
    tx_calm = 0;
    rx_calm = 0;
    in_live = 1'b0;
    cfg_live = 1'b0;
    tx_idle_pct = 38;
    rx_idle_pct = 61;

    // Reset values, constant words, an unmapped hole, a no-op request and an enable write.
    add_known(beat(REQ_READ, 0, 1'b0, OFS_ENABLE, '0), 32'h0, 1'b0, 1'b0);
    add_known(beat(REQ_READ, 31, 1'b1, OFS_PENDING, '1), 32'h0, 1'b0, 1'b0);
    add_known(beat(REQ_READ, 0, 1'b0, OFS_CLEAR, '0), 32'hffff_ffff, 1'b0, 1'b0);
    add_known(beat(REQ_READ, 0, 1'b0, OFS_MODE_LO, '0), 32'h0, 1'b0, 1'b0);
    add_known(beat(REQ_READ, 0, 1'b0, OFS_MODE_HI, '0), 32'h0, 1'b0, 1'b0);
    add_known(beat(REQ_READ, 0, 1'b0, OFS_NMI_REQ, '0), 32'h0, 1'b0, 1'b0);
    add_known(beat(REQ_READ, 0, 1'b0, OFS_NMI_CLR, '0), 32'h1, 1'b0, 1'b0);
    add_known(beat(REQ_READ, 0, 1'b0, 8'hff, '0), 32'h0, 1'b0, 1'b0);
    add_known(beat(REQ_NOP, 31, 1'b1, OFS_ENABLE, '1), 32'h0, 1'b0, 1'b0);
    add_known(beat(REQ_WRITE, 0, 1'b0, OFS_ENABLE, '1), 32'h0, 1'b0, 1'b0);
    // Low-level channels latch on a low pin at both ends of the channel range.
    add_beat(beat(REQ_PIN, 0, 1'b0, '0, '0));
    add_beat(beat(REQ_PIN, 31, 1'b0, '0, '0));
    add_beat(beat(REQ_READ, 0, 1'b0, OFS_PENDING, '0));
    add_beat(beat(REQ_PIN, 0, 1'b1, '0, '0));
    // Bus writes to the pending, mode and unmapped offsets must not land.
    add_beat(beat(REQ_WRITE, 0, 1'b0, OFS_PENDING, '1));
    add_beat(beat(REQ_WRITE, 0, 1'b0, OFS_MODE_LO, '1));
    add_beat(beat(REQ_WRITE, 0, 1'b0, 8'h1c, '1));
    // A full clear relatches the level channel whose pin is still asserted.
    add_beat(beat(REQ_WRITE, 0, 1'b0, OFS_CLEAR, '0));
    add_beat(beat(REQ_READ, 0, 1'b0, OFS_MODE_LO, '0));
    // Edge modes, channel 0 unrouted, and a write to the spare config index.
    add_cfg(CFG_MODE_LOW, 32'haaaa_aaaa);
    add_cfg(CFG_MODE_HIGH, 32'hffff_ffff);
    add_cfg(CFG_ROUTE, 32'hffff_fffe);
    add_cfg(CFG_SPARE, 32'h0);
    add_beat(beat(REQ_WRITE, 0, 1'b0, OFS_ENABLE, 32'h0000_0100));
    add_beat(beat(REQ_PIN, 8, 1'b0, '0, '0));
    add_beat(beat(REQ_PIN, 8, 1'b1, '0, '0));
    add_beat(beat(REQ_PIN, 0, 1'b0, '0, '0));
    add_beat(beat(REQ_PIN, 31, 1'b0, '0, '0));
    // Clearing never relatches edge channels; then the low group boundary.
    add_beat(beat(REQ_WRITE, 0, 1'b0, OFS_CLEAR, '0));
    add_beat(beat(REQ_WRITE, 0, 1'b0, OFS_ENABLE, 32'h0000_0080));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        quiesce();
        write_reg(script[i].cfg_idx, script[i].cfg_value);
      end else begin
        send_item(script[i].item, script[i].known, script[i].reply);
      end
    end

    // Random phases, each under its own mode and routing setting.
    for (int phase = 0; phase < PHASES; phase++) begin
      quiesce();
      if (phase < 3) begin
        tx_idle_pct = 38;
        rx_idle_pct = 61;
      end else if (phase < 6) begin
        tx_idle_pct = 61;
        rx_idle_pct = 38;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      lo = $urandom;
      hi = $urandom;
      rt = $urandom;
      case (phase)
        0: begin lo = '0; hi = '0; rt = '1; end
        1: begin lo = 32'h5555_5555; hi = 32'h5555_5555; rt = '1; end
        2: begin lo = 32'haaaa_aaaa; hi = 32'hffff_ffff; rt = '1; end
        4: begin lo = 32'hffff_ffff; hi = 32'haaaa_aaaa; rt = '0; end
        5, 7: rt = '1;
        default: ;
      endcase
      write_reg(CFG_MODE_LOW, lo);
      write_reg(CFG_MODE_HIGH, hi);
      write_reg(CFG_ROUTE, rt);
      if (phase % 2 == 1) begin
        write_reg(CFG_SPARE, $urandom);
      end
      repeat (BEATS_PER_PHASE) begin
        if ($urandom_range(0, 199) == 0) begin
          quiesce();
        end
        send_item(random_beat(), 1'b0, '0);
      end
    end

    quiesce();
    repeat (8) @(posedge clk);
    if (reply_q.size() != 0) begin
      mismatches += reply_q.size();
      $display("%0d replies never arrived", reply_q.size());
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/eilc_pkg.sv
hw/rtl/eilc_in_if.sv
hw/rtl/eilc_out_if.sv
hw/rtl/eilc_cfg_if.sv
hw/rtl/eilc_in_reg.sv
hw/rtl/eilc_core.sv
hw/rtl/eilc_out_reg.sv
hw/rtl/external_interrupt_latch_controller_core.sv
hw/rtl/eilc_checker.sv
test/testbench.sv
